/* rtl/bdpr_pkg.sv */
package bdpr_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int SLOTS_PER_BUTTON = 2;
    localparam int NUM_SLOTS = NUM_BUTTONS * SLOTS_PER_BUTTON;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int BTN_W = $clog2(NUM_BUTTONS);
    localparam int CFG_W = 16;
    localparam int TICK_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd3;

    localparam int BTN_UP = 0;
    localparam int BTN_DOWN = 1;
    localparam int BTN_BACK = 3;

    typedef enum logic [2:0] {
        EV_SHORT_PRESS  = 3'd0,
        EV_LONG_PRESS   = 3'd1,
        EV_REPEAT       = 3'd2,
        EV_RELEASE_LONG = 3'd3,
        EV_WAKE         = 3'd4
    } event_kind_t;

    typedef struct packed {
        event_kind_t       kind;
        logic [TICK_W-1:0] hold;
    } slot_t;

endpackage

/* rtl/button_debounce_press_repeat_unit.sv */
// Debounces four buttons (up, down, select, back) once per accepted tick item
// and reports wake, long-press, auto-repeat, short-press and release-after-long
// events. All per-button state is updated in the cycle the item is accepted;
// the events it causes (zero to seven) are parked in an event buffer and leave
// through the result register one per cycle while m_ready allows, in button
// order, the last one flagged with m_last_event. After an item causing no event
// or one event, the next tick can be taken back to back if m_ready is high; an
// item causing more events holds the input while they drain through the single
// result port. The next item is taken in the same cycle the buffer's final event moves out.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata.
module button_debounce_press_repeat_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [bdpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bdpr_pkg::CFG_W-1:0]            cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bdpr_pkg::NUM_BUTTONS-1:0]      s_raw_buttons,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [bdpr_pkg::BTN_W-1:0]            m_button_index,
    output logic [2:0]                            m_event_kind,
    output logic [bdpr_pkg::TICK_W-1:0]           m_hold_time,
    output logic [bdpr_pkg::TICK_W-1:0]           m_event_tick,
    output logic [bdpr_pkg::NUM_BUTTONS-1:0]      m_pressed_mask,
    output logic                                  m_last_event
);

    localparam int NB = bdpr_pkg::NUM_BUTTONS;
    localparam int NS = bdpr_pkg::NUM_SLOTS;
    localparam int TW = bdpr_pkg::TICK_W;
    localparam int CW = bdpr_pkg::CFG_W;

    // configuration
    logic [CW-1:0] debounce_reg, long_press_reg, repeat_delay_reg, repeat_interval_reg;

    // per-button state
    logic [TW-1:0] tick_reg;
    logic [NB-1:0] prior_raw_reg, prior_raw_next;
    logic [CW-1:0] stable_reg [NB];
    logic [CW-1:0] stable_next [NB];
    logic [NB-1:0] level_reg, level_next;
    logic [TW-1:0] press_start_reg [NB];
    logic [TW-1:0] press_start_next [NB];
    logic [TW-1:0] repeat_mark_reg [NB];
    logic [TW-1:0] repeat_mark_next [NB];
    logic [NB-1:0] long_rep_reg, long_rep_next;

    // event buffer
    logic [NS-1:0]          pend_reg, pend_next;
    bdpr_pkg::slot_t        slot_reg [NS];
    bdpr_pkg::slot_t        slot_next [NS];
    logic [TW-1:0]          buf_tick_reg;
    logic [NB-1:0]          buf_mask_reg;

    // result register
    logic                   m_valid_reg;
    logic [bdpr_pkg::BTN_W-1:0] m_button_reg;
    bdpr_pkg::event_kind_t  m_kind_reg;
    logic [TW-1:0]          m_hold_reg;
    logic [TW-1:0]          m_tick_reg;
    logic [NB-1:0]          m_mask_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic                   out_load;
    logic [bdpr_pkg::SLOT_W-1:0] pick_idx;
    logic [NS-1:0]          pend_after;

    assign out_load = (pend_reg != '0) && (!m_valid_reg || m_ready);

    always_comb begin
        pick_idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                pick_idx = i[bdpr_pkg::SLOT_W-1:0];
            end
        end
    end

    assign pend_after = pend_reg & ~(NS'(1) << pick_idx);

    // take a new item once the buffer is empty or its final event leaves now
    assign s_ready  = (pend_reg == '0) || (out_load && pend_after == '0);
    assign s_accept = s_valid && s_ready;

    // per-button lanes
    always_comb begin
        logic          raw, was, press, release_ev, held_ev;
        logic [CW-1:0] stab;
        logic [TW-1:0] hold, since_rep;
        bdpr_pkg::event_kind_t held_kind;

        for (int b = 0; b < NB; b++) begin
            raw = s_raw_buttons[b];
            was = level_reg[b];

            if (raw == prior_raw_reg[b]) begin
                stab = (stable_reg[b] < debounce_reg) ? stable_reg[b] + 1'b1 : stable_reg[b];
            end else begin
                stab = '0;
            end
            stable_next[b]    = stab;
            prior_raw_next[b] = raw;
            level_next[b]     = (stab >= debounce_reg) ? raw : was;

            press      = level_next[b] && !was;
            release_ev = !level_next[b] && was;

            press_start_next[b] = press ? tick_reg : press_start_reg[b];
            hold      = press ? '0 : tick_reg - press_start_reg[b];
            since_rep = press ? '0 : tick_reg - repeat_mark_reg[b];
            long_rep_next[b]    = press ? 1'b0 : long_rep_reg[b];
            repeat_mark_next[b] = press ? tick_reg : repeat_mark_reg[b];

            held_ev   = 1'b0;
            held_kind = bdpr_pkg::EV_REPEAT;
            if (level_next[b]) begin
                if (b == bdpr_pkg::BTN_BACK && !long_rep_next[b]
                    && hold >= TW'(long_press_reg)) begin
                    held_ev          = 1'b1;
                    held_kind        = bdpr_pkg::EV_LONG_PRESS;
                    long_rep_next[b] = 1'b1;
                end
                if ((b == bdpr_pkg::BTN_UP || b == bdpr_pkg::BTN_DOWN)
                    && hold >= TW'(repeat_delay_reg)
                    && since_rep >= TW'(repeat_interval_reg)) begin
                    held_ev             = 1'b1;
                    held_kind           = bdpr_pkg::EV_REPEAT;
                    repeat_mark_next[b] = tick_reg;
                end
            end

            // first slot: wake, else the held event, else the release
            pend_next[2*b]      = press || held_ev || release_ev;
            pend_next[2*b+1]    = press && held_ev;
            slot_next[2*b+1].kind = held_kind;
            slot_next[2*b+1].hold = hold;
            if (press) begin
                slot_next[2*b].kind = bdpr_pkg::EV_WAKE;
                slot_next[2*b].hold = '0;
            end else if (held_ev) begin
                slot_next[2*b].kind = held_kind;
                slot_next[2*b].hold = hold;
            end else begin
                slot_next[2*b].kind = long_rep_reg[b] ? bdpr_pkg::EV_RELEASE_LONG
                                                      : bdpr_pkg::EV_SHORT_PRESS;
                slot_next[2*b].hold = hold;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg        <= bdpr_pkg::DEBOUNCE_RST;
            long_press_reg      <= bdpr_pkg::LONG_PRESS_RST;
            repeat_delay_reg    <= bdpr_pkg::REPEAT_DELAY_RST;
            repeat_interval_reg <= bdpr_pkg::REPEAT_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bdpr_pkg::REG_DEBOUNCE:        debounce_reg        <= cfg_wdata;
                bdpr_pkg::REG_LONG_PRESS:      long_press_reg      <= cfg_wdata;
                bdpr_pkg::REG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_wdata;
                bdpr_pkg::REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            prior_raw_reg <= '0;
            level_reg     <= '0;
            long_rep_reg  <= '0;
            for (int b = 0; b < NB; b++) begin
                stable_reg[b]      <= '0;
                press_start_reg[b] <= '0;
                repeat_mark_reg[b] <= '0;
            end
        end else if (s_accept) begin
            tick_reg      <= tick_reg + 1'b1;
            prior_raw_reg <= prior_raw_next;
            level_reg     <= level_next;
            long_rep_reg  <= long_rep_next;
            for (int b = 0; b < NB; b++) begin
                stable_reg[b]      <= stable_next[b];
                press_start_reg[b] <= press_start_next[b];
                repeat_mark_reg[b] <= repeat_mark_next[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (s_accept) begin
            pend_reg <= pend_next;
        end else if (out_load) begin
            pend_reg <= pend_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            buf_tick_reg <= tick_reg;
            buf_mask_reg <= level_next;
            for (int i = 0; i < NS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_button_reg <= pick_idx[bdpr_pkg::SLOT_W-1:1];
            m_kind_reg   <= slot_reg[pick_idx].kind;
            m_hold_reg   <= slot_reg[pick_idx].hold;
            m_tick_reg   <= buf_tick_reg;
            m_mask_reg   <= buf_mask_reg;
            m_last_reg   <= (pend_after == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_button_index = m_button_reg;
    assign m_event_kind   = m_kind_reg;
    assign m_hold_time    = m_hold_reg;
    assign m_event_tick   = m_tick_reg;
    assign m_pressed_mask = m_mask_reg;
    assign m_last_event   = m_last_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import bdpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic [BTN_W-1:0]       button;
        event_kind_t            kind;
        logic [TICK_W-1:0]      hold;
        logic [TICK_W-1:0]      tick;
        logic [NUM_BUTTONS-1:0] mask;
        logic                   last;
    } button_event_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [NUM_BUTTONS-1:0] s_raw_buttons = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BTN_W-1:0]       m_button_index;
    logic [2:0]             m_event_kind;
    logic [TICK_W-1:0]      m_hold_time;
    logic [TICK_W-1:0]      m_event_tick;
    logic [NUM_BUTTONS-1:0] m_pressed_mask;
    logic                   m_last_event;

    // button state mirror
    logic [CFG_W-1:0]       cfg_debounce = DEBOUNCE_RST;
    logic [CFG_W-1:0]       cfg_long_press = LONG_PRESS_RST;
    logic [CFG_W-1:0]       cfg_repeat_delay = REPEAT_DELAY_RST;
    logic [CFG_W-1:0]       cfg_repeat_interval = REPEAT_INTERVAL_RST;
    logic [TICK_W-1:0]      tick_now = '0;
    logic [NUM_BUTTONS-1:0] prev_raw = '0;
    logic [NUM_BUTTONS-1:0] level = '0;
    logic [NUM_BUTTONS-1:0] long_done = '0;
    logic [CFG_W-1:0]       stable_cnt [NUM_BUTTONS] = '{default: '0};
    logic [TICK_W-1:0]      press_at [NUM_BUTTONS] = '{default: '0};
    logic [TICK_W-1:0]      repeat_tick [NUM_BUTTONS] = '{default: '0};

    button_event_t          expected_events [$];
    logic [NUM_BUTTONS-1:0] raw_ticks [$];
    button_event_t          head_ev;

    int  items_sent = 0;
    int  items_taken = 0;
    int  events_seen = 0;
    int  settings_used = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_offs = 0;
    int  holds_done = 0;
    bit  quiet_run = 1'b0;
    logic item_taken = 1'b0;

    button_debounce_press_repeat_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_buttons  (s_raw_buttons),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_index (m_button_index),
        .m_event_kind   (m_event_kind),
        .m_hold_time    (m_hold_time),
        .m_event_tick   (m_event_tick),
        .m_pressed_mask (m_pressed_mask),
        .m_last_event   (m_last_event)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic button_event_t ev_of(input int b, input event_kind_t k,
                                            input logic [TICK_W-1:0] h);
        button_event_t e;
        e.button = b[BTN_W-1:0];
        e.kind = k;
        e.hold = h;
        e.tick = '0;
        e.mask = '0;
        e.last = 1'b0;
        return e;
    endfunction

    // One tick of all four buttons; queues the events it raises, in button order.
    task automatic advance_buttons(input logic [NUM_BUTTONS-1:0] raw);
        button_event_t     found [$];
        button_event_t     e;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] held;
        logic              was;
        now = tick_now;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (raw[b] == prev_raw[b]) begin
                if (stable_cnt[b] < cfg_debounce)
                    stable_cnt[b] = stable_cnt[b] + 1'b1;
            end else begin
                stable_cnt[b] = '0;
                prev_raw[b] = raw[b];
            end
            was = level[b];
            // a count left above a lowered limit still counts as stable
            if (stable_cnt[b] >= cfg_debounce)
                level[b] = raw[b];
            if (level[b] && !was) begin
                press_at[b] = now;
                repeat_tick[b] = now;
                long_done[b] = 1'b0;
                found.push_back(ev_of(b, EV_WAKE, '0));
            end
            held = now - press_at[b];
            if (level[b]) begin
                if (b == BTN_BACK && !long_done[b] && held >= cfg_long_press) begin
                    found.push_back(ev_of(b, EV_LONG_PRESS, held));
                    long_done[b] = 1'b1;
                end
                if ((b == BTN_UP || b == BTN_DOWN) && held >= cfg_repeat_delay &&
                    (now - repeat_tick[b]) >= cfg_repeat_interval) begin
                    found.push_back(ev_of(b, EV_REPEAT, held));
                    repeat_tick[b] = now;
                end
            end else if (was) begin
                if (long_done[b])
                    found.push_back(ev_of(b, EV_RELEASE_LONG, held));
                else
                    found.push_back(ev_of(b, EV_SHORT_PRESS, held));
            end
        end
        foreach (found[k]) begin
            e = found[k];
            e.tick = now;
            e.mask = level;
            e.last = (k == found.size() - 1);
            expected_events.push_back(e);
        end
        tick_now = now + 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [TICK_W-1:0] got,
                                   input logic [TICK_W-1:0] want);
        $display("tick %0d: wrong %s, got 0x%0h, want 0x%0h", m_event_tick, what, got, want);
        errors++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEBOUNCE:        cfg_debounce = val;
            REG_LONG_PRESS:      cfg_long_press = val;
            REG_REPEAT_DELAY:    cfg_repeat_delay = val;
            REG_REPEAT_INTERVAL: cfg_repeat_interval = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input int deb, input int lp, input int rd, input int ri);
        set_reg(REG_DEBOUNCE, CFG_W'(deb));
        set_reg(REG_LONG_PRESS, CFG_W'(lp));
        set_reg(REG_REPEAT_DELAY, CFG_W'(rd));
        set_reg(REG_REPEAT_INTERVAL, CFG_W'(ri));
        settings_used++;
    endtask

    task automatic offer(input logic [NUM_BUTTONS-1:0] raw);
        raw_ticks.push_back(raw);
        items_sent++;
    endtask

    // all ticks taken, all events out, then a wait for the last quiet tick
    task automatic drain();
        while (items_taken != items_sent || expected_events.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // mostly held patterns, long enough to debounce limits up to 6, some short glitches
    task automatic random_phase(input int n_items);
        int sent;
        int len;
        logic [NUM_BUTTONS-1:0] pattern;
        sent = 0;
        while (sent < n_items) begin
            pattern = NUM_BUTTONS'($urandom_range(0, 15));
            if ($urandom_range(0, 9) < 8) begin
                len = (cfg_debounce > 6 ? 6 : int'(cfg_debounce)) + $urandom_range(1, 12);
                if ($urandom_range(0, 5) == 0)
                    len += 16;
            end else begin
                len = $urandom_range(1, 2);
            end
            if (len > n_items - sent)
                len = n_items - sent;
            repeat (len) offer(pattern);
            sent += len;
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (raw_ticks.size() > 0) begin
                s_valid <= 1'b1;
                s_raw_buttons <= raw_ticks.pop_front();
                gap_left = quiet_run ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (holds_done != hold_offs) begin
            m_ready <= 1'b0;
            hold_left = HOLD_OFF_CYCLES;
            holds_done++;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            item_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            item_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                advance_buttons(s_raw_buttons);
                items_taken++;
            end
            if (m_valid && m_ready) begin
                events_seen++;
                if (expected_events.size() == 0) begin
                    report_mismatch("event, none expected", TICK_W'(m_event_kind), '0);
                end else begin
                    head_ev = expected_events.pop_front();
                    if (m_button_index !== head_ev.button)
                        report_mismatch("button_index", TICK_W'(m_button_index),
                                        TICK_W'(head_ev.button));
                    if (m_event_kind !== head_ev.kind)
                        report_mismatch("event_kind", TICK_W'(m_event_kind),
                                        TICK_W'(head_ev.kind));
                    if (m_hold_time !== head_ev.hold)
                        report_mismatch("hold_time", m_hold_time, head_ev.hold);
                    if (m_event_tick !== head_ev.tick)
                        report_mismatch("event_tick", m_event_tick, head_ev.tick);
                    if (m_pressed_mask !== head_ev.mask)
                        report_mismatch("pressed_mask", TICK_W'(m_pressed_mask),
                                        TICK_W'(head_ev.mask));
                    if (m_last_event !== head_ev.last)
                        report_mismatch("last_event", TICK_W'(m_last_event),
                                        TICK_W'(head_ev.last));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("button_debounce_press_repeat_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero timing: wake, long press and first repeat all land on the press tick
        configure(0, 0, 0, 0);
        offer(4'hF);
        offer(4'hF);
        offer(4'h0);
        offer(4'hF);
        offer(4'h5);
        offer(4'hA);
        offer(4'h0);
        drain();

        // max limits: raw level never accepted, stable counts keep climbing
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (6) offer(4'h9);
        drain();

        // lowered debounce: counts already above it accept on the next tick
        configure(2, 3, 2, 1);
        repeat (5) offer(4'h9);
        repeat (3) offer(4'h0);
        drain();

        configure($urandom_range(0, 3), $urandom_range(0, 12),
                  $urandom_range(0, 8), $urandom_range(0, 4));
        hold_offs++;
        random_phase(32);
        drain();

        quiet_run = 1'b1;
        configure($urandom_range(0, 3), $urandom_range(0, 12),
                  $urandom_range(0, 8), $urandom_range(0, 4));
        random_phase(32);
        drain();
        quiet_run = 1'b0;

        configure(0, 0, 0, 0);
        hold_offs++;
        random_phase(32);
        drain();

        configure(16'hFFFF, 16'hFFFF, 0, 0);
        random_phase(10);
        drain();

        // wakes and short presses only
        configure(1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(32);
        drain();

        configure($urandom_range(0, 3), $urandom_range(0, 12),
                  $urandom_range(0, 8), $urandom_range(0, 4));
        random_phase(32);
        drain();

        configure($urandom_range(0, 3), $urandom_range(0, 12),
                  $urandom_range(0, 8), $urandom_range(0, 4));
        random_phase(32);
        drain();

        repeat (20) @(negedge aclk);
        $display("%0d ticks driven under %0d register settings, %0d events checked",
                 items_taken, settings_used, events_seen);
        $display("%0d receiver hold-offs of %0d cycles, %0d field errors",
                 holds_done, HOLD_OFF_CYCLES, errors);
        if (errors == 0)
            $display("button_debounce_press_repeat_unit: match");
        else
            $display("button_debounce_press_repeat_unit: mismatch");
        $finish;
    end

endmodule

/* button_debounce_press_repeat_unit.f */
rtl/bdpr_pkg.sv
rtl/button_debounce_press_repeat_unit.sv
tb/sv/tb.sv
